// ===== hdl/hinge_loss_subgradient_macros.svh =====
// Assertion macros for the hinge loss block
`ifndef HINGE_LOSS_SUBGRADIENT_MACROS_SVH
`define HINGE_LOSS_SUBGRADIENT_MACROS_SVH
`ifndef SYNTHESIS
`define HLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HLS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HLS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HLS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/hls_pkg.sv =====
package hls_pkg;
    localparam int DimMax = 64;
    localparam int IdxW = 6;
    localparam int SampleCountMax = 65536;
    localparam int CntW = 17;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_FEAT  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [IdxW-1:0] elem_index;
        logic signed [15:0] value;
        logic        label_negative;
        logic        last_feature;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] subgradient_element;
        logic [46:0] risk_sum;
        logic        saturated;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic       latch;     // capture input item
        logic       mac;       // multiply stage for a feature
        logic       acc;       // add product into dot
        logic       finish;    // hinge / risk update, start walk
        logic       walk;      // update one subgradient element
        logic       clr_regs;  // clear accumulators and subgradients
        logic       rd_out;    // load output register
        logic [IdxW-1:0] ptr;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       last;
        logic       do_walk;   // hinge nonzero and sample counted
    } dp_stat_t;
endpackage

// ===== hdl/hls_if.sv =====
interface hls_in_if;
    logic valid;
    logic ready;
    hls_pkg::in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface hls_out_if;
    logic valid;
    logic ready;
    hls_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/hinge_loss_subgradient.sv =====
// Linear SVM hinge-loss subgradient kernel, Q4.12 fixed point.
// Input channel "cmd_in" carries one command item: load weight, sample
// feature (with label and last-feature mark), read subgradient element, or
// clear. Output channel "result" carries one item per read command: the
// addressed subgradient element, the risk sum and the saturation flag.
// Items are taken one at a time by a sequencer over a shared datapath.
// Load and clear end after decode; a feature goes on to multiply and
// accumulate; a read goes on to the read state, which registers the result.
// A last feature then does the hinge and risk update, and when the hinge is
// nonzero the buffered sample is walked one element per cycle through the
// subgradient memory.
// Reset clears weights, accumulators and flags at once through per-entry
// valid bits; no clearing pass is needed.
// A result waits in the output register while the receiver stalls. Input
// items are still taken meanwhile; a further read holds in the sequencer
// until the output register is free, which then stalls the input.
module hinge_loss_subgradient (
    input logic clk,
    input logic rst_n,
    hls_in_if.sink cmd_in,
    hls_out_if.source result
);
    hls_pkg::dp_cmd_t  ctl;
    hls_pkg::dp_stat_t stat;

    hls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_in.valid),
        .in_ready  (cmd_in.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    hls_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (cmd_in.payload),
        .ctl      (ctl),
        .stat     (stat),
        .out_item (result.payload)
    );
endmodule

// ===== hdl/hls_datapath.sv =====
`include "hinge_loss_subgradient_macros.svh"
module hls_datapath (
    input  logic clk,
    input  logic rst_n,
    input  hls_pkg::in_item_t in_item,
    input  hls_pkg::dp_cmd_t ctl,
    output hls_pkg::dp_stat_t stat,
    output hls_pkg::out_item_t out_item
);
    logic signed [15:0] wmem [hls_pkg::DimMax];
    logic signed [15:0] sbuf [hls_pkg::DimMax];
    logic signed [31:0] gmem [hls_pkg::DimMax];
    logic [hls_pkg::DimMax-1:0] wvalid_reg, gvalid_reg, pres_reg;

    hls_pkg::in_item_t  item_reg;
    logic signed [15:0] wrd_reg, frd_reg;
    logic signed [31:0] grd_reg;
    logic signed [31:0] prod_reg;
    logic signed [47:0] dot_reg, dot_next;
    logic [46:0] risk_reg, risk_next;
    logic sat_reg, sat_next;
    logic [hls_pkg::CntW-1:0] cnt_reg;
    logic neg_reg, walk_en_reg;
    logic [5:0] ptr_d_reg;
    logic walk_d_reg, pres_d_reg;
    logic signed [48:0] dsum;
    logic signed [49:0] hinge;
    logic [48:0] rsum;
    logic signed [32:0] gsum;
    logic gsat;
    logic signed [31:0] gval;
    logic [5:0] ridx;

    // read address: latched item index normally, walk pointer during walks
    assign ridx = ctl.walk ? ctl.ptr : item_reg.elem_index;

    // memories with registered reads
    always_ff @(posedge clk)
    begin
        wrd_reg <= wmem[ridx];
        frd_reg <= sbuf[ridx];
        grd_reg <= gmem[ridx];
        if (ctl.latch && in_item.cmd == hls_pkg::CMD_LOAD)
        begin
            wmem[in_item.elem_index] <= in_item.value;
        end
        if (ctl.latch && in_item.cmd == hls_pkg::CMD_FEAT)
        begin
            sbuf[in_item.elem_index] <= in_item.value;
        end
        if (walk_d_reg)
        begin
            gmem[ptr_d_reg] <= gval;
        end
        if (ctl.latch)
        begin
            item_reg <= in_item;
        end
        if (ctl.mac)
        begin
            prod_reg <= item_reg.value * (wvalid_reg[item_reg.elem_index] ? wrd_reg : 16'sd0);
        end
        if (ctl.rd_out)
        begin
            out_item.subgradient_element <= gvalid_reg[item_reg.elem_index] ? grd_reg : '0;
            out_item.risk_sum <= risk_reg;
            out_item.saturated <= sat_reg;
        end
    end

    // subgradient update of the walked element
    assign gsum = (gvalid_reg[ptr_d_reg] ? 33'(grd_reg) : 33'sd0)
                + (neg_reg ? 33'(frd_reg) : -33'(frd_reg));
    assign gsat = (gsum > 33'sd2147483647) || (gsum < -33'sd2147483648);
    assign gval = (gsum > 33'sd2147483647) ? 32'sh7fffffff :
                  (gsum < -33'sd2147483648) ? 32'sh80000000 : gsum[31:0];

    // dot and hinge arithmetic
    assign dsum = 49'(dot_reg) + 49'(prod_reg);
    assign hinge = item_reg.label_negative ? (50'sd16777216 + 50'(dot_reg))
                                           : (50'sd16777216 - 50'(dot_reg));
    assign rsum = 49'(risk_reg) + ((hinge > 0) ? 49'(hinge[47:0]) : 49'd0);

    always_comb
    begin
        dot_next = dot_reg;
        risk_next = risk_reg;
        sat_next = sat_reg;
        if (ctl.acc)
        begin
            if (dsum > 49'sh7fffffffffff)
            begin
                dot_next = 48'sh7fffffffffff;
                sat_next = 1'b1;
            end
            else if (dsum < -49'sh800000000000)
            begin
                dot_next = 48'sh800000000000;
                sat_next = 1'b1;
            end
            else
            begin
                dot_next = dsum[47:0];
            end
        end
        if (ctl.finish)
        begin
            dot_next = '0;
            if (cnt_reg < hls_pkg::CntW'(hls_pkg::SampleCountMax))
            begin
                if (rsum[48:47] != 2'b00)
                begin
                    risk_next = '1;
                    sat_next = 1'b1;
                end
                else
                begin
                    risk_next = rsum[46:0];
                end
            end
        end
        if (walk_d_reg && pres_d_reg && gsat)
        begin
            sat_next = 1'b1;
        end
        if (ctl.clr_regs)
        begin
            dot_next = '0;
            risk_next = '0;
            sat_next = 1'b0;
        end
    end

    // control-side state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= '0;
            gvalid_reg <= '0;
            pres_reg <= '0;
            dot_reg <= '0;
            risk_reg <= '0;
            sat_reg <= 1'b0;
            cnt_reg <= '0;
            neg_reg <= 1'b0;
            walk_en_reg <= 1'b0;
            walk_d_reg <= 1'b0;
            pres_d_reg <= 1'b0;
            ptr_d_reg <= '0;
        end
        else
        begin
            dot_reg <= dot_next;
            risk_reg <= risk_next;
            sat_reg <= sat_next;
            walk_d_reg <= ctl.walk && pres_reg[ctl.ptr];
            pres_d_reg <= pres_reg[ctl.ptr];
            ptr_d_reg <= ctl.ptr;
            if (ctl.latch && in_item.cmd == hls_pkg::CMD_LOAD)
            begin
                wvalid_reg[in_item.elem_index] <= 1'b1;
            end
            if (ctl.latch && in_item.cmd == hls_pkg::CMD_FEAT)
            begin
                pres_reg[in_item.elem_index] <= 1'b1;
            end
            if (walk_d_reg)
            begin
                gvalid_reg[ptr_d_reg] <= 1'b1;
            end
            if (ctl.finish)
            begin
                neg_reg <= item_reg.label_negative;
                walk_en_reg <= (cnt_reg < hls_pkg::CntW'(hls_pkg::SampleCountMax))
                               && (hinge > 0);
                if (cnt_reg < hls_pkg::CntW'(hls_pkg::SampleCountMax))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (!((cnt_reg < hls_pkg::CntW'(hls_pkg::SampleCountMax)) && (hinge > 0)))
                begin
                    pres_reg <= '0;
                end
            end
            if (ctl.walk && ctl.ptr == 6'(hls_pkg::DimMax - 1))
            begin
                pres_reg <= '0;
            end
            if (ctl.clr_regs)
            begin
                gvalid_reg <= '0;
                pres_reg <= '0;
                cnt_reg <= '0;
            end
        end
    end

    assign stat.cmd = item_reg.cmd;
    assign stat.last = item_reg.last_feature;
    assign stat.do_walk = walk_en_reg;

    `HLS_ASSERT_NXT(a_clr_risk, clk, rst_n, ctl.clr_regs, risk_reg == '0)
    `HLS_ASSERT_NXT(a_clr_sat, clk, rst_n, ctl.clr_regs, !sat_reg)
    `HLS_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1,
        cnt_reg <= hls_pkg::CntW'(hls_pkg::SampleCountMax))
endmodule

// ===== hdl/hls_ctrl.sv =====
`include "hinge_loss_subgradient_macros.svh"
module hls_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  hls_pkg::dp_stat_t stat,
    output hls_pkg::dp_cmd_t ctl
);
    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_MAC, S_ACC, S_FIN, S_WALK, S_CLR, S_RD
    } state_t;

    state_t state_reg;
    logic [5:0] ptr_reg;
    logic out_valid_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        ctl = '0;
        ctl.ptr = ptr_reg;
        unique case (state_reg)
            S_IDLE: ctl.latch = in_valid;
            S_MAC: ctl.mac = 1'b1;
            S_ACC: ctl.acc = 1'b1;
            S_FIN: ctl.finish = 1'b1;
            S_WALK: ctl.walk = 1'b1;
            S_CLR: ;
            // a read waits here while the output register is still occupied
            S_RD: ctl.rd_out = !out_valid_reg || out_ready;
            S_DEC: ctl.clr_regs = (stat.cmd == hls_pkg::CMD_CLEAR);
        endcase
    end

    // sequencer: one item at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= ctl.rd_out || (out_valid_reg && !out_ready);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    ptr_reg <= '0;
                    unique case (hls_pkg::cmd_t'(stat.cmd))
                        hls_pkg::CMD_LOAD: state_reg <= S_IDLE;
                        hls_pkg::CMD_FEAT: state_reg <= S_MAC;
                        hls_pkg::CMD_READ: state_reg <= S_RD;
                        hls_pkg::CMD_CLEAR: state_reg <= S_IDLE;
                    endcase
                end
                S_MAC: state_reg <= S_ACC;
                S_ACC: state_reg <= stat.last ? S_FIN : S_IDLE;
                S_FIN:
                begin
                    state_reg <= S_CLR;
                end
                S_CLR:
                begin
                    state_reg <= stat.do_walk ? S_WALK : S_IDLE;
                end
                S_WALK:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == 6'(hls_pkg::DimMax - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RD:
                begin
                    if (ctl.rd_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `HLS_ASSERT_IMP(a_rdy_idle, clk, rst_n, in_ready, state_reg == S_IDLE)
    `HLS_ASSERT_NXT(a_rd_out, clk, rst_n, state_reg == S_RD, out_valid_reg)
    `HLS_ASSERT_IMP(a_walk_only, clk, rst_n, state_reg == S_WALK, stat.do_walk)
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    localparam longint OneQ24 = longint'(1) << 24;
    localparam longint DotHi = (longint'(1) << 47) - 1;
    localparam longint DotLo = -(longint'(1) << 47);
    localparam longint RiskHi = (longint'(1) << 47) - 1;
    localparam longint SubHi = 64'sd2147483647;
    localparam longint SubLo = -64'sd2147483648;
    localparam int StallLimit = 3000;
    localparam int HoldCycles = 400;

    logic clk;
    logic rst_n;

    hls_in_if cmd_if ();
    hls_out_if res_if ();

    hinge_loss_subgradient uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_in (cmd_if.sink),
        .result (res_if.source)
    );

    // shadow copy of the kernel state
    logic signed [15:0] shadow_weight [hls_pkg::DimMax];
    logic signed [15:0] shadow_feat [hls_pkg::DimMax];
    bit                 feat_seen [hls_pkg::DimMax];
    logic signed [31:0] shadow_subgrad [hls_pkg::DimMax];
    longint             shadow_dot;
    longint             shadow_risk;
    bit                 shadow_sat;
    int                 samples_counted;

    hls_pkg::out_item_t pending_reads [$];

    int errors = 0;
    int items_sent = 0;
    int reads_checked = 0;
    int sample_ends = 0;
    int send_gap_max = 11;
    int recv_stall_max = 11;
    bit hold_request = 0;

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic longint clamp_sat(longint v, longint lo, longint hi);
        if (v > hi)
        begin
            shadow_sat = 1;
            return hi;
        end
        if (v < lo)
        begin
            shadow_sat = 1;
            return lo;
        end
        return v;
    endfunction

    function automatic void clear_shadow_accs();
        for (int j = 0; j < hls_pkg::DimMax; j++)
        begin
            shadow_subgrad[j] = '0;
            feat_seen[j] = 0;
        end
        shadow_dot = 0;
        shadow_risk = 0;
        shadow_sat = 0;
        samples_counted = 0;
    endfunction

    // end of sample: hinge into risk, subgradient walk if hinge nonzero
    function automatic void close_sample(bit neg);
        longint hinge;
        longint s;
        sample_ends++;
        if (samples_counted < hls_pkg::SampleCountMax)
        begin
            samples_counted++;
            hinge = neg ? OneQ24 + shadow_dot : OneQ24 - shadow_dot;
            if (hinge < 0)
                hinge = 0;
            shadow_risk = clamp_sat(shadow_risk + hinge, 0, RiskHi);
            if (hinge != 0)
            begin
                for (int j = 0; j < hls_pkg::DimMax; j++)
                begin
                    if (feat_seen[j])
                    begin
                        s = longint'(shadow_subgrad[j]) +
                            (neg ? longint'(shadow_feat[j]) : -longint'(shadow_feat[j]));
                        shadow_subgrad[j] = 32'(clamp_sat(s, SubLo, SubHi));
                    end
                end
            end
        end
        shadow_dot = 0;
        for (int j = 0; j < hls_pkg::DimMax; j++)
            feat_seen[j] = 0;
    endfunction

    // predict the effect of one accepted command
    function automatic void predict_command(hls_pkg::in_item_t it);
        hls_pkg::out_item_t r;
        case (hls_pkg::cmd_t'(it.cmd))
            hls_pkg::CMD_LOAD:
                shadow_weight[it.elem_index] = it.value;
            hls_pkg::CMD_FEAT:
            begin
                shadow_feat[it.elem_index] = it.value;
                feat_seen[it.elem_index] = 1;
                shadow_dot = clamp_sat(shadow_dot + longint'(it.value) *
                    longint'(shadow_weight[it.elem_index]), DotLo, DotHi);
                if (it.last_feature)
                    close_sample(it.label_negative);
            end
            hls_pkg::CMD_READ:
            begin
                r.subgradient_element = shadow_subgrad[it.elem_index];
                r.risk_sum = shadow_risk[46:0];
                r.saturated = shadow_sat;
                pending_reads.insert(pending_reads.size(), r);
            end
            default:
                clear_shadow_accs();
        endcase
    endfunction

    function automatic hls_pkg::in_item_t make_item(hls_pkg::cmd_t c, int idx,
                                                    logic [15:0] v, bit neg, bit last);
        hls_pkg::in_item_t it;
        it.cmd = c;
        it.elem_index = idx[5:0];
        it.value = v;
        it.label_negative = neg;
        it.last_feature = last;
        return it;
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // drive one item and wait for it to be taken
    task automatic send_item(hls_pkg::in_item_t it);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            cmd_if.payload <= hls_pkg::in_item_t'(26'($urandom));
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.payload <= it;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        predict_command(it);
        items_sent++;
    endtask

    task automatic send_sample(int len, bit neg);
        for (int k = 0; k < len; k++)
            send_item(make_item(hls_pkg::CMD_FEAT, $urandom_range(0, hls_pkg::DimMax - 1),
                                pick_value(), neg, k == len - 1));
    endtask

    // result side: random stalls, long hold on request, check each item
    initial
    begin
        int stall;
        hls_pkg::out_item_t want;
        hls_pkg::out_item_t got;
        stall = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
            begin
                got = res_if.payload;
                if (pending_reads.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result item %h", $time, got);
                end
                else
                begin
                    want = pending_reads.pop_front();
                    reads_checked++;
                    if (got.subgradient_element !== want.subgradient_element)
                    begin
                        errors++;
                        $display("%0t: subgradient_element expected %0d got %0d", $time,
                                 want.subgradient_element, got.subgradient_element);
                    end
                    if (got.risk_sum !== want.risk_sum)
                    begin
                        errors++;
                        $display("%0t: risk_sum expected %0d got %0d", $time,
                                 want.risk_sum, got.risk_sum);
                    end
                    if (got.saturated !== want.saturated)
                    begin
                        errors++;
                        $display("%0t: saturated expected %b got %b", $time,
                                 want.saturated, got.saturated);
                    end
                end
                stall = $urandom_range(0, recv_stall_max);
            end
            if (hold_request)
            begin
                hold_request = 0;
                stall = HoldCycles;
            end
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                stall--;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no item moving
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= StallLimit)
            begin
                $display("timeout after %0d idle cycles", quiet);
                $display("hinge_loss_subgradient: mismatch");
                $finish;
            end
        end
    end

    // extremes, both labels, zero hinge, repeated index, clear
    task automatic test_directed();
        send_item(make_item(hls_pkg::CMD_LOAD, 0, 16'h7FFF, 1'b0, 1'b0));
        send_item(make_item(hls_pkg::CMD_LOAD, 63, 16'h8000, 1'b0, 1'b0));
        send_item(make_item(hls_pkg::CMD_LOAD, 5, 16'h1000, 1'b0, 1'b0));
        // large dot, hinge zero
        send_item(make_item(hls_pkg::CMD_FEAT, 0, 16'h7FFF, 1'b0, 1'b1));
        send_item(make_item(hls_pkg::CMD_READ, 0, 16'h0000, 1'b0, 1'b0));
        send_item(make_item(hls_pkg::CMD_FEAT, 63, 16'h7FFF, 1'b0, 1'b0));
        // negative dot, label +1
        send_item(make_item(hls_pkg::CMD_FEAT, 5, 16'h8000, 1'b0, 1'b1));
        send_item(make_item(hls_pkg::CMD_READ, 63, 16'h0000, 1'b0, 1'b0));
        send_item(make_item(hls_pkg::CMD_READ, 5, 16'h0000, 1'b0, 1'b0));
        // repeated index
        send_item(make_item(hls_pkg::CMD_FEAT, 5, 16'h0100, 1'b1, 1'b0));
        send_item(make_item(hls_pkg::CMD_FEAT, 5, 16'hFF00, 1'b1, 1'b0));
        send_item(make_item(hls_pkg::CMD_FEAT, 63, 16'h8000, 1'b1, 1'b1));
        send_item(make_item(hls_pkg::CMD_READ, 5, 16'h0000, 1'b0, 1'b0));
        // zero dot, label -1
        send_item(make_item(hls_pkg::CMD_FEAT, 12, 16'h0000, 1'b1, 1'b1));
        send_item(make_item(hls_pkg::CMD_READ, 12, 16'h0000, 1'b0, 1'b0));
        send_item(make_item(hls_pkg::CMD_READ, 63, 16'h0000, 1'b1, 1'b1));
        send_item(make_item(hls_pkg::CMD_CLEAR, 0, 16'hFFFF, 1'b1, 1'b1));
        send_item(make_item(hls_pkg::CMD_READ, 63, 16'h0000, 1'b0, 1'b0));
        // partial sample cut by clear
        send_item(make_item(hls_pkg::CMD_FEAT, 0, 16'h7FFF, 1'b0, 1'b0));
        send_item(make_item(hls_pkg::CMD_CLEAR, 0, 16'h0000, 1'b0, 1'b0));
        send_item(make_item(hls_pkg::CMD_FEAT, 1, 16'h4000, 1'b0, 1'b1));
        send_item(make_item(hls_pkg::CMD_READ, 0, 16'h0000, 1'b0, 1'b0));
        send_item(make_item(hls_pkg::CMD_READ, 1, 16'h0000, 1'b0, 1'b0));
    endtask

    // mostly whole samples with random content, plus loads, reads, clears, noise
    task automatic test_random(int n);
        int stop_at;
        int pick;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_item(make_item(hls_pkg::CMD_LOAD, $urandom_range(0, hls_pkg::DimMax - 1),
                                    pick_value(), 1'($urandom), 1'($urandom)));
            else if (pick < 62)
                send_sample($urandom_range(1, 8), 1'($urandom));
            else if (pick < 90)
                send_item(make_item(hls_pkg::CMD_READ, $urandom_range(0, hls_pkg::DimMax - 1),
                                    16'($urandom), 1'($urandom), 1'($urandom)));
            else if (pick < 93)
                send_item(make_item(hls_pkg::CMD_CLEAR, $urandom_range(0, hls_pkg::DimMax - 1),
                                    16'($urandom), 1'($urandom), 1'($urandom)));
            else
                send_item(hls_pkg::in_item_t'(26'($urandom)));
        end
    endtask

    // receiver holds off while reads keep coming
    task automatic test_backpressure();
        send_gap_max = 0;
        hold_request = 1;
        for (int k = 0; k < 20; k++)
            send_item(make_item(hls_pkg::CMD_READ, $urandom_range(0, hls_pkg::DimMax - 1),
                                16'h0000, 1'b0, 1'b0));
        send_gap_max = 11;
    endtask

    // both sides at full rate
    task automatic test_full_rate();
        send_gap_max = 0;
        recv_stall_max = 0;
        test_random(120);
        send_gap_max = 11;
        recv_stall_max = 11;
    endtask

    initial
    begin
        for (int j = 0; j < hls_pkg::DimMax; j++)
        begin
            shadow_weight[j] = '0;
            shadow_feat[j] = '0;
        end
        clear_shadow_accs();
        cmd_if.valid = 1'b0;
        cmd_if.payload = '0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        test_directed();
        test_random(450);
        test_backpressure();
        test_full_rate();
        test_random(450);

        cmd_if.valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("covered %0d command items, %0d sample ends, %0d reads checked",
                 items_sent, sample_ends, reads_checked);
        $display("saturation seen in shadow state: %b", shadow_sat);
        if (errors == 0)
            $display("hinge_loss_subgradient: match");
        else
            $display("hinge_loss_subgradient: mismatch");
        $finish;
    end
endmodule
